// ----- rtl/bffa_pkg.sv -----
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants, codes and controller/datapath interface types for the
// bitmap first-fit block allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int BLOCK_COUNT = 512;
  localparam int BLOCK_BYTES = 8;
  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 13;
  localparam int STATUS_W    = 2;

  localparam int WORD_BITS   = 8;
  localparam int WORD_COUNT  = BLOCK_COUNT / WORD_BITS;
  localparam int IDX_W       = $clog2(BLOCK_COUNT);
  localparam int CNT_W       = IDX_W + 1;
  localparam int WORD_W      = $clog2(WORD_COUNT);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int NEED_W      = SIZE_W - OFF_W + 1;
  localparam int POOL_BYTES  = BLOCK_COUNT * BLOCK_BYTES;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_RUN   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic load;
    logic decide;
    logic scan_eval;
    logic mark_write;
    logic push;
  } bffa_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic need_zero;
    logic free_ok;
    logic scan_found;
    logic scan_last;
    logic mark_last;
    logic out_free;
  } bffa_stat_t;

endpackage

// ----- rtl/bffa_dp.sv -----
// ----------------------------------------------------------------------------
// bffa_dp
// Allocator datapath: used map memory, request registers, first-fit scan
// over one map word per step, run marking/clearing and result register.
// ----------------------------------------------------------------------------
module bffa_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [bffa_pkg::ADDR_W-1:0]      cfg_data,
  input  logic                             opcode,
  input  logic [bffa_pkg::SIZE_W-1:0]      size_bytes,
  input  logic [bffa_pkg::ADDR_W-1:0]      free_address,
  input  bffa_pkg::bffa_cmd_t              cmd,
  output bffa_pkg::bffa_stat_t             stat,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bffa_pkg::ADDR_W-1:0]      alloc_address,
  output logic [bffa_pkg::STATUS_W-1:0]    status
);
  import bffa_pkg::*;

  logic [ADDR_W-1:0]    pool_base;
  logic                 op;
  logic [NEED_W-1:0]    need;
  logic [ADDR_W-1:0]    faddr;
  logic [WORD_W-1:0]    word;
  logic [NEED_W-1:0]    run;
  logic [CNT_W-1:0]     start;
  logic [CNT_W-1:0]     lo;
  logic [CNT_W-1:0]     hi;
  logic [WORD_W-1:0]    last_word;
  logic                 set_val;
  logic [ADDR_W-1:0]    res_addr;
  logic [STATUS_W-1:0]  res_status;

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] row_valid;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_valid;
  logic [WORD_BITS-1:0] cur_word;

  logic [SIZE_W:0]      size_sum;
  logic [NEED_W-1:0]    need_in;

  logic [ADDR_W-1:0]    off;
  logic                 free_ok;
  logic [IDX_W-1:0]     free_start;
  logic [NEED_W:0]      free_sum;
  logic [CNT_W-1:0]     free_hi;
  logic [CNT_W-1:0]     free_hi_m1;

  logic [NEED_W-1:0]    s_run;
  logic [CNT_W-1:0]     s_start;
  logic                 s_found;
  logic [NEED_W:0]      hit_sum;
  logic [CNT_W-1:0]     hit_hi;
  logic [CNT_W-1:0]     hit_hi_m1;

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] wdata;

  assign size_sum = {1'b0, size_bytes} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
  assign need_in  = size_sum[SIZE_W:OFF_W];

  assign cur_word = rd_valid ? rd_data : '0;

  // free address check
  assign off        = faddr - pool_base;
  assign free_ok    = (faddr >= pool_base) && (faddr[OFF_W-1:0] == '0) &&
                      (off < ADDR_W'(POOL_BYTES));
  assign free_start = off[OFF_W+IDX_W-1:OFF_W];
  assign free_sum   = (NEED_W + 1)'(free_start) + {1'b0, need};
  assign free_hi    = (free_sum > (NEED_W + 1)'(BLOCK_COUNT)) ? CNT_W'(BLOCK_COUNT)
                                                              : free_sum[CNT_W-1:0];
  assign free_hi_m1 = free_hi - CNT_W'(1);

  // first-fit step over one map word
  always_comb begin
    s_run   = run;
    s_start = start;
    s_found = 1'b0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!s_found) begin
        if (cur_word[b]) begin
          s_start = {1'b0, word, BIT_W'(b)} + CNT_W'(1);
          s_run   = '0;
        end else begin
          s_run = s_run + NEED_W'(1);
        end
        if (s_run >= need) begin
          s_found = 1'b1;
        end
      end
    end
  end

  assign hit_sum   = (NEED_W + 1)'(s_start) + {1'b0, need};
  assign hit_hi    = hit_sum[CNT_W-1:0];
  assign hit_hi_m1 = hit_hi - CNT_W'(1);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = ({1'b0, word, BIT_W'(b)} >= lo) && ({1'b0, word, BIT_W'(b)} < hi);
    end
  end

  assign wdata = set_val ? (cur_word | mask) : (cur_word & ~mask);

  assign stat.is_alloc   = (op == OP_ALLOC);
  assign stat.need_zero  = (need == '0);
  assign stat.free_ok    = free_ok;
  assign stat.scan_found = s_found;
  assign stat.scan_last  = (word == WORD_W'(WORD_COUNT - 1));
  assign stat.mark_last  = (word == last_word);
  assign stat.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.mark_write) begin
      mem[word] <= wdata;
    end
    rd_data <= mem[word];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (cmd.mark_write) begin
        row_valid[word] <= 1'b1;
      end
      rd_valid <= row_valid[word];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (cfg_valid) begin
      pool_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= opcode;
      need  <= need_in;
      faddr <= free_address;
    end

    if (cmd.decide) begin
      if (op == OP_ALLOC) begin
        word       <= '0;
        run        <= '0;
        start      <= '0;
        res_addr   <= pool_base;
        res_status <= ST_OK;
      end else if (!free_ok) begin
        res_addr   <= '0;
        res_status <= ST_BAD_ADDR;
      end else begin
        res_addr   <= '0;
        res_status <= ST_OK;
        lo         <= CNT_W'(free_start);
        hi         <= free_hi;
        word       <= free_start[IDX_W-1:BIT_W];
        last_word  <= free_hi_m1[IDX_W-1:BIT_W];
        set_val    <= 1'b0;
      end
    end

    if (cmd.scan_eval) begin
      if (s_found) begin
        lo         <= s_start;
        hi         <= hit_hi;
        word       <= s_start[IDX_W-1:BIT_W];
        last_word  <= hit_hi_m1[IDX_W-1:BIT_W];
        set_val    <= 1'b1;
        res_addr   <= pool_base + (ADDR_W'(s_start[IDX_W-1:0]) << OFF_W);
        res_status <= ST_OK;
      end else if (word == WORD_W'(WORD_COUNT - 1)) begin
        res_addr   <= '0;
        res_status <= ST_NO_RUN;
      end else begin
        run  <= s_run;
        start <= s_start;
        word <= word + WORD_W'(1);
      end
    end

    if (cmd.mark_write) begin
      word <= word + WORD_W'(1);
    end

    if (cmd.push) begin
      alloc_address <= res_addr;
      status        <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/bffa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bffa_ctrl
// Allocator controller: sequences request load, decode, word scan,
// read-modify-write of the used map and result hand-off.
// ----------------------------------------------------------------------------
module bffa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bffa_pkg::bffa_stat_t stat,
  output bffa_pkg::bffa_cmd_t  cmd
);
  import bffa_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECIDE    = 3'd1;
  localparam logic [2:0] S_SCAN_RD   = 3'd2;
  localparam logic [2:0] S_SCAN_EVAL = 3'd3;
  localparam logic [2:0] S_MARK_RD   = 3'd4;
  localparam logic [2:0] S_MARK_WR   = 3'd5;
  localparam logic [2:0] S_RESULT    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.is_alloc) begin
          state_next = stat.need_zero ? S_RESULT : S_SCAN_RD;
        end else if (!stat.free_ok || stat.need_zero) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_MARK_RD;
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_EVAL;
      end
      S_SCAN_EVAL: begin
        cmd.scan_eval = 1'b1;
        if (stat.scan_found) begin
          state_next = S_MARK_RD;
        end else if (stat.scan_last) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_MARK_RD: begin
        state_next = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.mark_write = 1'b1;
        state_next     = stat.mark_last ? S_RESULT : S_MARK_RD;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/bitmap_first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator
// First-fit allocator of contiguous 8-byte blocks from a 512-block pool.
//
// Input channel (in_valid/in_stall) carries one request per beat: opcode
// allocate or free, size_bytes and free_address. Output channel
// (out_valid/out_stall) returns one beat per request: alloc_address and
// status. cfg_valid/cfg_ready writes pool_base; cfg_ready is always high.
// The used map is held as 64 words of 8 bits and is scanned one word at a
// time (memory read, then first-fit step), and marked or cleared by a
// read-modify-write (memory read, then write) of each touched word. One
// request is handled at a time: a zero-size request or a rejected free goes
// straight to its result, a free marks only the words it touches, and an
// allocate scans words in order until it finds a run, up to all 64 words.
// Reset clears the used map (per-word valid bits, no clearing pass) and
// pool_base. A finished result waits in the output register while the
// receiver stalls; the next request is taken meanwhile and held at its
// result until that register frees up.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bffa_pkg::ADDR_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             opcode,
  input  logic [bffa_pkg::SIZE_W-1:0]      size_bytes,
  input  logic [bffa_pkg::ADDR_W-1:0]      free_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bffa_pkg::ADDR_W-1:0]      alloc_address,
  output logic [bffa_pkg::STATUS_W-1:0]    status
);
  import bffa_pkg::*;

  bffa_cmd_t  cmd;
  bffa_stat_t stat;

  assign cfg_ready = 1'b1;

  bffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bffa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .opcode        (opcode),
    .size_bytes    (size_bytes),
    .free_address  (free_address),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .alloc_address (alloc_address),
    .status        (status)
  );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap first-fit block allocator. A tracker
// class keeps its own used map and pool base. It predicts the address and
// status of every accepted request and checks each returned beat in order.
// A short directed run covers the edge cases. Random phases follow under
// several pool bases. Most of that traffic is allocate requests and frees of
// live runs; the rest is bad frees and odd sizes. Random idling is applied
// on both channels, except in the last phase.
// ----------------------------------------------------------------------------
module testbench;
  import bffa_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [STATUS_W-1:0] status;
  } grant_t;

  class pool_tracker;
    bit                used [BLOCK_COUNT];
    logic [ADDR_W-1:0] base;
    grant_t            grants_q [$];
    int                errors, n_checked, n_alloc_ok, n_no_run, n_free_ok, n_bad_addr;

    function new();
      base = '0;
      foreach (used[i]) used[i] = 1'b0;
      errors = 0; n_checked = 0; n_alloc_ok = 0;
      n_no_run = 0; n_free_ok = 0; n_bad_addr = 0;
    endfunction

    function void set_base(logic [ADDR_W-1:0] v);
      base = v;
    endfunction

    function int outstanding();
      return grants_q.size();
    endfunction

    function grant_t note(logic op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] fa);
      grant_t            g;
      int                need, start, run, stop;
      logic [ADDR_W-1:0] off;
      need     = (int'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
      g.addr   = '0;
      g.status = ST_OK;
      if (op == OP_ALLOC) begin
        start = 0;
        run   = 0;
        for (int i = 0; i < BLOCK_COUNT && run < need; i++) begin
          if (used[i]) begin
            start = i + 1;
            run   = 0;
          end else begin
            run++;
          end
        end
        if (run < need) begin
          g.status = ST_NO_RUN;
          n_no_run++;
        end else begin
          for (int i = start; i < start + need; i++) used[i] = 1'b1;
          g.addr = base + ADDR_W'(start * BLOCK_BYTES);
          n_alloc_ok++;
        end
      end else begin
        off = fa - base;
        if (fa < base || fa[OFF_W-1:0] != '0 || off >= ADDR_W'(POOL_BYTES)) begin
          g.status = ST_BAD_ADDR;
          n_bad_addr++;
        end else begin
          start = int'(off >> OFF_W);
          stop  = start + need;
          if (stop > BLOCK_COUNT) stop = BLOCK_COUNT;
          for (int i = start; i < stop; i++) used[i] = 1'b0;
          n_free_ok++;
        end
      end
      grants_q.push_back(g);
      return g;
    endfunction

    function void check(logic [ADDR_W-1:0] a, logic [STATUS_W-1:0] s);
      grant_t g;
      if (grants_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual addr %h status %0d",
                 $time, a, s);
        return;
      end
      g = grants_q.pop_front();
      n_checked++;
      if (a !== g.addr) begin
        errors++;
        $display("%0t: alloc_address expected %h actual %h", $time, g.addr, a);
      end
      if (s !== g.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, g.status, s);
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    int first;
    int blocks;
  } live_run_t;

  logic                clk;
  logic                rst          = 1'b1;
  logic                cfg_valid    = 1'b0;
  logic [ADDR_W-1:0]   cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic                opcode       = OP_ALLOC;
  logic [SIZE_W-1:0]   size_bytes   = '0;
  logic [ADDR_W-1:0]   free_address = '0;
  logic                out_stall    = 1'b0;
  logic                cfg_ready, in_stall, out_valid;
  logic [ADDR_W-1:0]   alloc_address;
  logic [STATUS_W-1:0] status;

  pool_tracker sb = new();
  live_run_t   live_q [$];
  bit          quiet = 1'b0;
  int          stall_cnt = 0;
  int          cycles = 0;
  int          n_items = 0;

  bitmap_first_fit_block_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .size_bytes   (size_bytes),
    .free_address (free_address),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .alloc_address(alloc_address),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycles, sb.outstanding());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: check accepted beats, random stall bursts
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) sb.check(alloc_address, status);
    if (quiet) begin
      stall_cnt = 0;
      out_stall <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_cnt = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic put_req(logic op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] fa);
    grant_t g;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    size_bytes   <= size;
    free_address <= fa;
    do @(posedge clk); while (in_stall !== 1'b0);
    g = sb.note(op, size, fa);
    n_items++;
    if (op == OP_ALLOC && g.status == ST_OK && size != '0)
      live_q.push_back('{int'((g.addr - sb.base) >> OFF_W),
                         (int'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES});
  endtask

  task automatic hold_input();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic write_base(logic [ADDR_W-1:0] v);
    hold_input();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_base(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int n);
    int                r, idx;
    live_run_t         e;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] fa;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45 || (r < 85 && live_q.size() == 0)) begin
        case ($urandom_range(0, 19))
          0:       sz = '0;
          1:       sz = SIZE_W'($urandom_range(0, 4096));
          2:       sz = SIZE_W'($urandom_range(129, 1024));
          default: sz = SIZE_W'($urandom_range(1, 128));
        endcase
        put_req(OP_ALLOC, sz, $urandom);
      end else if (r < 85) begin
        idx = $urandom_range(0, live_q.size() - 1);
        e   = live_q[idx];
        live_q.delete(idx);
        put_req(OP_FREE, SIZE_W'(e.blocks * BLOCK_BYTES - $urandom_range(0, 7)),
                sb.base + ADDR_W'(e.first * BLOCK_BYTES));
      end else if (r < 88) begin
        put_req(OP_FREE, SIZE_W'(POOL_BYTES), sb.base);
        live_q.delete();
      end else if (r < 93) begin
        put_req(OP_FREE, SIZE_W'($urandom_range(0, 256)),
                sb.base + ADDR_W'($urandom_range(0, BLOCK_COUNT - 1) * BLOCK_BYTES));
      end else begin
        sz = SIZE_W'($urandom_range(0, 4096));
        case ($urandom_range(0, 3))
          0: fa = $urandom;
          1: fa = sb.base + ADDR_W'($urandom_range(0, BLOCK_COUNT - 1) * BLOCK_BYTES
                                    + $urandom_range(1, 7));
          2: fa = sb.base - ADDR_W'($urandom_range(1, 4) * BLOCK_BYTES);
          default: fa = sb.base + ADDR_W'(POOL_BYTES + $urandom_range(0, 3) * BLOCK_BYTES);
        endcase
        put_req(OP_FREE, sz, fa);
      end
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] v;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    b = 32'h0000_1000;
    write_base(b);
    put_req(OP_ALLOC, 0, 32'hFFFF_FFFF);
    put_req(OP_ALLOC, 1, 0);
    put_req(OP_ALLOC, 8, 0);
    put_req(OP_ALLOC, 9, 0);
    put_req(OP_ALLOC, 4096, 0);
    put_req(OP_FREE, 8, b + 8);
    put_req(OP_ALLOC, 7, 0);
    put_req(OP_FREE, 8, b - 8);
    put_req(OP_FREE, 8, b + 4096);
    put_req(OP_FREE, 4096, b + 4088);
    put_req(OP_FREE, 8, b + 3);
    put_req(OP_FREE, 0, b + 16);
    put_req(OP_FREE, 64, b + 800);
    put_req(OP_FREE, 4096, b);
    put_req(OP_ALLOC, 4096, 0);
    put_req(OP_ALLOC, 1, 0);
    put_req(OP_FREE, 4096, b);
    put_req(OP_FREE, 8, 32'hFFFF_FFFF);
    put_req(OP_ALLOC, 4089, 32'h5555_5555);
    put_req(OP_FREE, 4095, b);

    // pool at the top of the address space, grants wrap to zero
    b = 32'hFFFF_FFF8;
    write_base(b);
    put_req(OP_ALLOC, 0, 0);
    put_req(OP_ALLOC, 16, 0);
    put_req(OP_ALLOC, 8, 0);
    put_req(OP_FREE, 16, b);
    put_req(OP_FREE, 8, 32'h0000_0008);
    put_req(OP_FREE, 4096, b);
    live_q.delete();

    write_base(32'h0000_0000);
    run_phase(150);
    write_base(32'hFFFF_FFF8);
    run_phase(60);
    v = $urandom;
    v[OFF_W-1:0] = '0;
    write_base(v);
    run_phase(80);
    hold_input();
    run_phase(80);
    v = $urandom;
    v[OFF_W-1:0] = OFF_W'($urandom_range(1, 7));
    write_base(v);
    run_phase(40);
    write_base(32'hFFFF_F000);
    run_phase(100);
    write_base(32'h8000_0000);
    run_phase(100);
    v = $urandom;
    v[OFF_W-1:0] = '0;
    quiet = 1'b1;
    write_base(v);
    run_phase(140);

    hold_input();
    repeat (300) @(posedge clk);
    $display("%0d requests under 9 pool bases: %0d grants, %0d refused for room,",
             n_items, sb.n_alloc_ok, sb.n_no_run);
    $display("%0d frees taken, %0d frees rejected on address, %0d beats compared",
             sb.n_free_ok, sb.n_bad_addr, sb.n_checked);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bffa_pkg.sv
rtl/bffa_dp.sv
rtl/bffa_ctrl.sv
rtl/bitmap_first_fit_block_allocator.sv
sim/testbench.sv
